// ===== hdl/lhc_pkg.sv =====
// ---------------------------------------------------------------------------
// lhc_pkg
// Shared constants and the log-linear bucket limit table for the latency
// histogram collector.
// ---------------------------------------------------------------------------
`default_nettype none

package lhc_pkg;

  localparam int IDX_W  = 8;
  localparam int DATA_W = 64;

  // Request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Power of ten for one decade of sixteen limits
  function automatic logic [DATA_W-1:0] pow10(input logic [3:0] d);
    logic [DATA_W-1:0] p;
    unique case (d)
      4'd0:  p = 64'd1;
      4'd1:  p = 64'd10;
      4'd2:  p = 64'd100;
      4'd3:  p = 64'd1000;
      4'd4:  p = 64'd10000;
      4'd5:  p = 64'd100000;
      4'd6:  p = 64'd1000000;
      4'd7:  p = 64'd10000000;
      4'd8:  p = 64'd100000000;
      4'd9:  p = 64'd1000000000;
      4'd10: p = 64'd10000000000;
      4'd11: p = 64'd100000000000;
      4'd12: p = 64'd1000000000000;
      4'd13: p = 64'd10000000000000;
      4'd14: p = 64'd100000000000000;
      4'd15: p = 64'd1000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

  // Upper limit of bucket i: 1..10, then mantissa times a power of ten
  function automatic logic [DATA_W-1:0] limit_of(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0]  j;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] lim;
    j = i - 8'd10;
    p = pow10(j[7:4]);
    unique case (j[3:0])
      4'd0:  lim = p * 64'd12;
      4'd1:  lim = p * 64'd14;
      4'd2:  lim = p * 64'd16;
      4'd3:  lim = p * 64'd18;
      4'd4:  lim = p * 64'd20;
      4'd5:  lim = p * 64'd25;
      4'd6:  lim = p * 64'd30;
      4'd7:  lim = p * 64'd35;
      4'd8:  lim = p * 64'd40;
      4'd9:  lim = p * 64'd45;
      4'd10: lim = p * 64'd50;
      4'd11: lim = p * 64'd60;
      4'd12: lim = p * 64'd70;
      4'd13: lim = p * 64'd80;
      4'd14: lim = p * 64'd90;
      4'd15: lim = p * 64'd100;
      default: lim = p;
    endcase
    if (i < 8'd10) begin
      lim = 64'(i) + 64'd1;
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lhc_search.sv =====
// ---------------------------------------------------------------------------
// lhc_search
// Binary search for the first bucket whose limit is at least the sample.
// Each probe fetches the limit, then compares and narrows the window.
// ---------------------------------------------------------------------------
`default_nettype none

module lhc_search #(
  parameter int BUCKETS = 138
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [lhc_pkg::DATA_W-1:0] value,
  output logic                            done,
  output logic [lhc_pkg::IDX_W-1:0]       index
);

  localparam logic [lhc_pkg::IDX_W-1:0] IDX_LAST = lhc_pkg::IDX_W'(BUCKETS - 1);

  logic                        running;
  logic                        phase;
  logic [lhc_pkg::IDX_W-1:0]   lo;
  logic [lhc_pkg::IDX_W-1:0]   hi;
  logic [lhc_pkg::IDX_W-1:0]   mid;
  logic [lhc_pkg::DATA_W-1:0]  lim;
  logic [lhc_pkg::IDX_W-1:0]   mid_calc;
  logic [lhc_pkg::IDX_W-1:0]   lo_next;
  logic [lhc_pkg::IDX_W-1:0]   hi_next;
  logic                        go_low;

  // Midpoint of the open window
  assign mid_calc = lhc_pkg::IDX_W'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // Narrow the window after a compare
  assign go_low  = (lim >= value);
  assign lo_next = go_low ? lo : lhc_pkg::IDX_W'(mid + 8'd1);
  assign hi_next = go_low ? mid : hi;

  // Control: start, alternate fetch/compare, finish when the window closes
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && phase && (lo_next == hi_next);
      if (start) begin
        running <= 1'b1;
        phase   <= 1'b0;
      end else if (running) begin
        phase <= ~phase;
        if (phase && (lo_next == hi_next)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Window and limit registers
  always_ff @(posedge clk) begin
    if (start) begin
      lo <= '0;
      hi <= IDX_LAST;
    end else if (running) begin
      if (!phase) begin
        mid <= mid_calc;
        lim <= lhc_pkg::limit_of(mid_calc);
      end else begin
        lo <= lo_next;
        hi <= hi_next;
      end
    end
  end

  assign index = lo;

endmodule

`default_nettype wire

// ===== hdl/latency_histogram_collector_top.sv =====
// ---------------------------------------------------------------------------
// latency_histogram_collector_top
// Log-linear latency histogram: bucket counts in one synchronous memory,
// min / max / count / sum / sum of squares in registers.
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, req_type,            | request
//          | sample_value, bucket_select              |
//  out     | out_valid, out_stall, bucket_index,      | one beat
//          | bucket_count, sample_total, smallest,    | per request
//          | largest, value_sum, square_sum           |
//
//  One request at a time. Add: the bucket search, whose probes each fetch a
//  limit and then compare, followed by the memory read-modify-write.
//  Read: accept, memory read, result. Clear: one memory row cleared per cycle.
//  After reset the memory is swept with in_stall high.
//  A result waits in the output register while out_stall is high.
// ---------------------------------------------------------------------------
`default_nettype none

module latency_histogram_collector_top #(
  parameter int BUCKETS = 138
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  req_type,
  input  wire logic [lhc_pkg::DATA_W-1:0]  sample_value,
  input  wire logic [lhc_pkg::IDX_W-1:0]   bucket_select,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lhc_pkg::IDX_W-1:0]        bucket_index,
  output logic [lhc_pkg::DATA_W-1:0]       bucket_count,
  output logic [lhc_pkg::DATA_W-1:0]       sample_total,
  output logic [lhc_pkg::DATA_W-1:0]       smallest,
  output logic [lhc_pkg::DATA_W-1:0]       largest,
  output logic [lhc_pkg::DATA_W-1:0]       value_sum,
  output logic [lhc_pkg::DATA_W-1:0]       square_sum
);

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [lhc_pkg::IDX_W-1:0]  IDX_LAST  = lhc_pkg::IDX_W'(BUCKETS - 1);
  localparam logic [lhc_pkg::DATA_W-1:0] MIN_RESET = lhc_pkg::limit_of(IDX_LAST);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0]                  state;
  logic [1:0]                  kind;
  logic                        reply;
  logic [lhc_pkg::DATA_W-1:0]  val;
  logic [lhc_pkg::IDX_W-1:0]   idx;
  logic [lhc_pkg::IDX_W-1:0]   ptr;
  logic [lhc_pkg::DATA_W-1:0]  rd_data;
  logic [lhc_pkg::DATA_W-1:0]  prod_lo;
  logic [30:0]                 prod_mid;
  logic [30:0]                 prod_mid_full;

  logic [lhc_pkg::DATA_W-1:0]  min_seen, min_seen_next;
  logic [lhc_pkg::DATA_W-1:0]  max_seen, max_seen_next;
  logic [lhc_pkg::DATA_W-1:0]  count_seen, count_seen_next;
  logic [lhc_pkg::DATA_W-1:0]  sum_seen, sum_seen_next;
  logic [lhc_pkg::DATA_W-1:0]  squares_seen, squares_seen_next;
  logic [lhc_pkg::DATA_W-1:0]  cnt_inc;
  logic [lhc_pkg::DATA_W-1:0]  square;

  logic [lhc_pkg::DATA_W-1:0]  mem [BUCKETS];

  logic                        accept;
  logic                        slot_free;
  logic                        finish;
  logic                        is_add;
  logic                        srch_start;
  logic                        srch_done;
  logic [lhc_pkg::IDX_W-1:0]   srch_index;
  logic [lhc_pkg::IDX_W-1:0]   sel_sat;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign slot_free  = !out_valid || !out_stall;
  assign finish     = (state == S_UPDATE) && slot_free;
  assign is_add     = (kind == lhc_pkg::REQ_ADD);
  assign srch_start = accept && (req_type == lhc_pkg::REQ_ADD);
  assign sel_sat    = ({1'b0, bucket_select} >= 9'(BUCKETS)) ? IDX_LAST : bucket_select;

  // Bucket search
  lhc_search #(
    .BUCKETS (BUCKETS)
  ) u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .value (val),
    .done  (srch_done),
    .index (srch_index)
  );

  // Square modulo 2^64 from a 32x32 and a 31x31 partial product
  assign prod_mid_full = val[30:0] * val[62:32];
  always_ff @(posedge clk) begin
    prod_lo  <= 64'(val[31:0]) * 64'(val[31:0]);
    prod_mid <= prod_mid_full;
  end
  assign square = prod_lo + {prod_mid, 33'd0};

  // Bucket count memory: one write port, registered read
  assign cnt_inc = rd_data + 64'd1;
  always_ff @(posedge clk) begin
    rd_data <= mem[idx[AW-1:0]];
    if (state == S_CLEAR) begin
      mem[ptr[AW-1:0]] <= '0;
    end else if (finish && is_add) begin
      mem[idx[AW-1:0]] <= cnt_inc;
    end
  end

  // Statistics after an add
  always_comb begin
    min_seen_next     = (val < min_seen) ? val : min_seen;
    max_seen_next     = (val > max_seen) ? val : max_seen;
    count_seen_next   = count_seen + 64'd1;
    sum_seen_next     = sum_seen + val;
    squares_seen_next = squares_seen + square;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
      reply <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (ptr == IDX_LAST) begin
            ptr   <= '0;
            state <= reply ? S_UPDATE : S_IDLE;
          end else begin
            ptr <= lhc_pkg::IDX_W'(ptr + 8'd1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              lhc_pkg::REQ_ADD:   state <= S_SEARCH;
              lhc_pkg::REQ_CLEAR: begin
                state <= S_CLEAR;
                reply <= 1'b1;
              end
              default:            state <= S_READ;
            endcase
          end
        end
        S_SEARCH: begin
          if (srch_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (slot_free) begin
            state <= S_IDLE;
            reply <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request payload: latch on accept, take the found bucket after the search
  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= req_type;
      val  <= sample_value;
      idx  <= (req_type == lhc_pkg::REQ_CLEAR) ? '0 : sel_sat;
    end else if ((state == S_SEARCH) && srch_done) begin
      idx <= srch_index;
    end
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    if (rst || ((state == S_CLEAR) && (ptr == IDX_LAST))) begin
      min_seen     <= MIN_RESET;
      max_seen     <= '0;
      count_seen   <= '0;
      sum_seen     <= '0;
      squares_seen <= '0;
    end else if (finish && is_add) begin
      min_seen     <= min_seen_next;
      max_seen     <= max_seen_next;
      count_seen   <= count_seen_next;
      sum_seen     <= sum_seen_next;
      squares_seen <= squares_seen_next;
    end
  end

  // Output register: hold while stalled, drop after the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      bucket_index <= idx;
      if (is_add) begin
        bucket_count <= cnt_inc;
        sample_total <= count_seen_next;
        smallest     <= min_seen_next;
        largest      <= max_seen_next;
        value_sum    <= sum_seen_next;
        square_sum   <= squares_seen_next;
      end else begin
        bucket_count <= (kind == lhc_pkg::REQ_CLEAR) ? '0 : rd_data;
        sample_total <= count_seen;
        smallest     <= min_seen;
        largest      <= max_seen;
        value_sum    <= sum_seen;
        square_sum   <= squares_seen;
      end
    end
  end

  // Assertions
  a_rose_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_UPDATE))
    else $error("result beat raised outside the update step");

  a_add_counts_one: assert property (@(posedge clk) disable iff (rst)
    (finish && is_add) |=> (count_seen == $past(count_seen) + 64'd1))
    else $error("sample count did not advance by one on an add");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    ((count_seen != 64'd0) && !(state == S_CLEAR)) |-> (min_seen <= max_seen))
    else $error("minimum above maximum with samples recorded");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, bucket_index} < 9'(BUCKETS)))
    else $error("bucket index beyond the last bucket");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |=> !$past(accept))
    else $error("request taken while a search was running");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the latency histogram collector. A short table of
// directed requests covers reset values, range extremes, saturated reads, the
// unused request code, wrap-around and clear. Random adds, reads and clears
// follow under four idle/stall patterns. Every result beat is compared field
// by field against the typed expectation of its row or the histogram predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int          NBUCKETS    = 138;
  localparam logic [7:0]  LAST_BUCKET = 8'(NBUCKETS - 1);
  localparam logic [1:0]  REQ_SPARE   = 2'd3;
  localparam int          RAND_PHASE  = 340;
  localparam int          CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0]  index;
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] sum;
    logic [63:0] sq;
  } hist_result_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [63:0]  value;
    logic [7:0]   sel;
    logic         typed;
    hist_result_t want;
  } hist_req_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [63:0] sample_value;
  logic [7:0]  bucket_select;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  bucket_index;
  logic [63:0] bucket_count;
  logic [63:0] sample_total;
  logic [63:0] smallest;
  logic [63:0] largest;
  logic [63:0] value_sum;
  logic [63:0] square_sum;

  // Typed expectation travelling with the beat on the wire
  logic         cur_typed;
  hist_result_t cur_want;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int cycle_count;
  int adds_seen;
  int reads_seen;
  int clears_seen;
  int spares_seen;

  // Predictor state
  logic [63:0] tally [NBUCKETS];
  bit          bucket_hit [NBUCKETS];
  logic [63:0] low_mark;
  logic [63:0] high_mark;
  logic [63:0] total_mark;
  logic [63:0] sum_mark;
  logic [63:0] sq_mark;

  hist_result_t expected_results [$];
  hist_req_t    directed_rows [$];

  int unsigned decade_steps [16] = '{12, 14, 16, 18, 20, 25, 30, 35,
                                     40, 45, 50, 60, 70, 80, 90, 100};

  latency_histogram_collector_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .sample_value  (sample_value),
    .bucket_select (bucket_select),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bucket_index  (bucket_index),
    .bucket_count  (bucket_count),
    .sample_total  (sample_total),
    .smallest      (smallest),
    .largest       (largest),
    .value_sum     (value_sum),
    .square_sum    (square_sum)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Upper limit of a bucket: 1..10, then sixteen steps per decade
  function automatic logic [63:0] bucket_ceiling(int b);
    logic [63:0] lim;
    int          k;
    if (b < 10) return 64'(b + 1);
    lim = 64'(decade_steps[(b - 10) % 16]);
    for (k = 0; k < (b - 10) / 16; k++) lim = lim * 64'd10;
    return lim;
  endfunction

  // First bucket whose limit covers the sample
  function automatic logic [7:0] bucket_for(logic [63:0] v);
    int b;
    if (v >= bucket_ceiling(NBUCKETS - 1)) return LAST_BUCKET;
    if (v == 64'd0) return 8'd0;
    for (b = 0; b < NBUCKETS; b++) begin
      if (bucket_ceiling(b) >= v) return 8'(b);
    end
    return LAST_BUCKET;
  endfunction

  function automatic void clear_stats();
    int b;
    for (b = 0; b < NBUCKETS; b++) tally[b] = 64'd0;
    low_mark   = bucket_ceiling(NBUCKETS - 1);
    high_mark  = 64'd0;
    total_mark = 64'd0;
    sum_mark   = 64'd0;
    sq_mark    = 64'd0;
  endfunction

  // Apply one request to the predictor and return its result beat
  function automatic hist_result_t apply_request(logic [1:0] kind, logic [63:0] v,
                                                 logic [7:0] sel);
    hist_result_t r;
    logic [7:0]   b;
    case (kind)
      lhc_pkg::REQ_ADD: begin
        b = bucket_for(v);
        tally[b] = tally[b] + 64'd1;
        bucket_hit[b] = 1'b1;
        if (v < low_mark) low_mark = v;
        if (v > high_mark) high_mark = v;
        total_mark = total_mark + 64'd1;
        sum_mark   = sum_mark + v;
        sq_mark    = sq_mark + v * v;
      end
      lhc_pkg::REQ_CLEAR: begin
        clear_stats();
        b = 8'd0;
      end
      default: begin
        b = (sel >= 8'(NBUCKETS)) ? LAST_BUCKET : sel;
      end
    endcase
    r.index = b;
    r.count = tally[b];
    r.total = total_mark;
    r.low   = low_mark;
    r.high  = high_mark;
    r.sum   = sum_mark;
    r.sq    = sq_mark;
    return r;
  endfunction

  function automatic hist_result_t mk_result(logic [7:0] idx, logic [63:0] cnt,
                                             logic [63:0] tot, logic [63:0] lo,
                                             logic [63:0] hi, logic [63:0] sm,
                                             logic [63:0] sq);
    hist_result_t r;
    r = {idx, cnt, tot, lo, hi, sm, sq};
    return r;
  endfunction

  function automatic void add_row(logic [1:0] kind, logic [63:0] v, logic [7:0] sel,
                                  logic typed, hist_result_t want);
    hist_req_t row;
    row.kind  = kind;
    row.value = v;
    row.sel   = sel;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Sample values biased toward bucket edges and the whole 64-bit range
  function automatic logic [63:0] draw_sample();
    logic [63:0] v;
    int          b;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        b = $urandom_range(0, NBUCKETS - 1);
        v = bucket_ceiling(b) + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3, 4:    v = {$urandom, $urandom} >> $urandom_range(34, 63);
      5:       v = 64'($urandom_range(0, 12));
      6:       v = {$urandom, $urandom};
      7:       v = 64'd999999998 + 64'($urandom_range(0, 4));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  function automatic hist_req_t draw_request();
    hist_req_t r;
    int        pick;
    pick    = $urandom_range(0, 99);
    r.value = draw_sample();
    r.sel   = 8'($urandom_range(0, 255));
    r.typed = 1'b0;
    r.want  = '0;
    if (pick < 70)      r.kind = lhc_pkg::REQ_ADD;
    else if (pick < 90) r.kind = lhc_pkg::REQ_READ;
    else if (pick < 95) r.kind = REQ_SPARE;
    else                r.kind = lhc_pkg::REQ_CLEAR;
    return r;
  endfunction

  // Present one request beat and hold it until accepted
  task automatic send_beat(input hist_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= r.kind;
    sample_value  <= r.value;
    bucket_select <= r.sel;
    cur_typed     <= r.typed;
    cur_want      <= r.want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(input hist_result_t want, input hist_result_t got);
    check_field("bucket_index", 64'(want.index), 64'(got.index));
    check_field("bucket_count", want.count, got.count);
    check_field("sample_total", want.total, got.total);
    check_field("smallest",     want.low,   got.low);
    check_field("largest",      want.high,  got.high);
    check_field("value_sum",    want.sum,   got.sum);
    check_field("square_sum",   want.sq,    got.sq);
  endtask

  // Random receiver stall, updated on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check result beats and predict accepted request beats
  always @(posedge clk) begin : scoreboard
    hist_result_t got;
    hist_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {bucket_index, bucket_count, sample_total, smallest, largest,
             value_sum, square_sum};
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_result(want, got);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      want = apply_request(req_type, sample_value, bucket_select);
      if (cur_typed) want = cur_want;
      expected_results.insert(expected_results.size(), want);
      case (req_type)
        lhc_pkg::REQ_ADD:   adds_seen++;
        lhc_pkg::REQ_READ:  reads_seen++;
        lhc_pkg::REQ_CLEAR: clears_seen++;
        default:            spares_seen++;
      endcase
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    hist_result_t fresh;
    hist_result_t none;
    logic [63:0]  all_ones;
    int           p;
    int           hits;
    int           b;

    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = lhc_pkg::REQ_ADD;
    sample_value   = 64'd0;
    bucket_select  = 8'd0;
    out_stall      = 1'b0;
    cur_typed      = 1'b0;
    cur_want       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    adds_seen      = 0;
    reads_seen     = 0;
    clears_seen    = 0;
    spares_seen    = 0;
    for (b = 0; b < NBUCKETS; b++) bucket_hit[b] = 1'b0;
    clear_stats();

    all_ones = '1;
    none     = '0;
    fresh    = mk_result(8'd0, 64'd0, 64'd0, 64'd1000000000, 64'd0, 64'd0, 64'd0);

    // Directed table: reset values, extremes, wrap, saturated read, clear
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd0, 1'b1, fresh);
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd137, 1'b1,
            mk_result(8'd137, 64'd0, 64'd0, 64'd1000000000, 64'd0, 64'd0, 64'd0));
    add_row(lhc_pkg::REQ_ADD, 64'd0, 8'd0, 1'b1,
            mk_result(8'd0, 64'd1, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0));
    add_row(lhc_pkg::REQ_ADD, 64'd1000000000, 8'd0, 1'b1,
            mk_result(8'd137, 64'd1, 64'd2, 64'd0, 64'd1000000000, 64'd1000000000,
                      64'd1000000000000000000));
    add_row(lhc_pkg::REQ_ADD, all_ones, 8'hff, 1'b1,
            mk_result(8'd137, 64'd2, 64'd3, 64'd0, all_ones, 64'd999999999,
                      64'd1000000000000000001));
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd255, 1'b1,
            mk_result(8'd137, 64'd2, 64'd3, 64'd0, all_ones, 64'd999999999,
                      64'd1000000000000000001));
    add_row(REQ_SPARE, 64'd0, 8'd0, 1'b1,
            mk_result(8'd0, 64'd1, 64'd3, 64'd0, all_ones, 64'd999999999,
                      64'd1000000000000000001));
    add_row(lhc_pkg::REQ_CLEAR, all_ones, 8'hff, 1'b1, fresh);
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd200, 1'b1,
            mk_result(8'd137, 64'd0, 64'd0, 64'd1000000000, 64'd0, 64'd0, 64'd0));
    add_row(lhc_pkg::REQ_ADD, 64'd1, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd10, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd11, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd12, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd13, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd1200, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd1201, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd2500, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd10000000, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd999999999, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'd1000000001, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, 64'h8000_0000_0000_0000, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_ADD, all_ones, 8'd0, 1'b0, none);
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd138, 1'b0, none);
    add_row(REQ_SPARE, all_ones, 8'd255, 1'b0, none);
    add_row(lhc_pkg::REQ_READ, 64'd0, 8'd10, 1'b0, none);

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    // Random phases: no idling, sender idle, receiver stall, both
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      repeat (RAND_PHASE) send_beat(draw_request());
    end

    // Drain the remaining results
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (NBUCKETS + 64) @(posedge clk);

    hits = 0;
    for (b = 0; b < NBUCKETS; b++) if (bucket_hit[b]) hits++;
    $display("Covered %0d adds, %0d reads, %0d clears, %0d unused-code requests",
             adds_seen, reads_seen, clears_seen, spares_seen);
    $display("Samples landed in %0d of %0d buckets", hits, NBUCKETS);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== latency_histogram_collector_top.f =====
hdl/lhc_pkg.sv
hdl/lhc_search.sv
hdl/latency_histogram_collector_top.sv
tb/tb.sv
